/* rtl/biqc_pkg.sv */
// Shared types, constants and helpers for the biquad cascade filter.
// No dependencies; the ALU, the top level and the checker in rtl/ import it.
`timescale 1ns / 1ps

package biqc_pkg;

    localparam int MAX_BIQUADS_DEF  = 8;
    localparam int COEFS_PER_BIQUAD = 7;
    localparam int DELAYS_PER_BIQUAD = 2;
    localparam int SAMPLE_W         = 32;
    localparam int CFG_W            = 4;
    localparam int ACC_W            = 64;

    // Input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // Register index (byte address bit 2)
    localparam logic REG_BIQUAD_COUNT  = 1'b0;
    localparam logic REG_SERIES_LENGTH = 1'b1;

    // Coefficient slot inside one biquad
    localparam logic [2:0] K_A2    = 3'd0;
    localparam logic [2:0] K_A1    = 3'd1;
    localparam logic [2:0] K_B2    = 3'd2;
    localparam logic [2:0] K_B1    = 3'd3;
    localparam logic [2:0] K_B0    = 3'd4;
    localparam logic [2:0] K_SHIFT = 3'd5;
    localparam logic [2:0] K_GAIN  = 3'd6;

    // Arithmetic constants
    localparam logic signed [ACC_W-1:0] ROUND_Q30 = 64'sh0000_0000_2000_0000;
    localparam int                      Q30_SHIFT = 30;
    localparam logic signed [32:0]      GAIN_SHIFT_BASE = 33'sd14;
    localparam logic signed [32:0]      SHIFT_MIN = 33'sd1;
    localparam logic signed [32:0]      SHIFT_MAX = 33'sd62;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BRANCH,
        ST_S0,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_S4,
        ST_S5,
        ST_S6,
        ST_S7,
        ST_S8,
        ST_S9,
        ST_BR_END,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_state step;
        logic   load_x;
        logic   branch_init;
        logic   pass_x;
    } t_alu_ctl;

    function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/biqc_coef_ram.sv */
// Coefficient store: one write port, one registered read port.
// Depends on nothing; contents are undefined until written.
`timescale 1ns / 1ps

module biqc_coef_ram #(
    parameter int DEPTH = 56,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/biqc_delay_ram.sv */
// Delay-line store with per-entry valid bits; invalid entries read as zero.
// Depends on nothing; registered read port, one write port.
`timescale 1ns / 1ps

module biqc_delay_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [63:0]      r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

/* rtl/biqc_alu.sv */
// Shared multiply-accumulate datapath, stepped by the sequencer in the top level.
// Depends on biqc_pkg (t_alu_ctl, t_state, sat32 and arithmetic constants).
`timescale 1ns / 1ps

module biqc_alu #(
    parameter int MAX_BIQUADS = biqc_pkg::MAX_BIQUADS_DEF
) (
    input  logic                     i_clk,
    input  biqc_pkg::t_alu_ctl       i_ctl,
    input  logic signed [31:0]       i_value,
    input  logic signed [31:0]       i_coef,
    input  logic signed [63:0]       i_delay,
    output logic signed [63:0]       o_acc,
    output logic signed [63:0]       o_acc2,
    output logic signed [31:0]       o_total
);

    import biqc_pkg::*;

    localparam int TW = SAMPLE_W + $clog2(MAX_BIQUADS + 1) + 1;
    localparam logic signed [TW-1:0] T_MAX = TW'(32'sh7FFF_FFFF);
    localparam logic signed [TW-1:0] T_MIN = TW'(32'sh8000_0000);

    logic signed [31:0] r_x;
    logic signed [31:0] r_sig;
    logic signed [31:0] r_y;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_d0;
    logic signed [63:0] r_d1;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_acc2;
    logic        [5:0]  r_sh;
    logic signed [TW-1:0] r_total;

    logic signed [31:0] w_mul_b;
    logic signed [63:0] w_prod;
    logic signed [32:0] w_sh_sum;
    logic        [5:0]  w_sh_clamped;
    logic signed [63:0] w_round;

    // Multiplier operand: the branch signal for feed-forward taps, y for the rest
    always_comb begin
        case (i_ctl.step)
            ST_S4, ST_S5, ST_S7: w_mul_b = r_y;
            default:             w_mul_b = r_sig;
        endcase
    end

    assign w_prod   = i_coef * w_mul_b;
    assign w_sh_sum = {i_coef[31], i_coef} + GAIN_SHIFT_BASE;
    assign w_round  = 64'sd1 <<< (r_sh - 6'd1);

    always_comb begin
        if (w_sh_sum < SHIFT_MIN) begin
            w_sh_clamped = SHIFT_MIN[5:0];
        end else if (w_sh_sum > SHIFT_MAX) begin
            w_sh_clamped = SHIFT_MAX[5:0];
        end else begin
            w_sh_clamped = w_sh_sum[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_x) begin
            r_x     <= i_value;
            r_total <= '0;
        end
        if (i_ctl.branch_init) begin
            r_sig <= r_x;
        end
        if (i_ctl.pass_x) begin
            r_total <= TW'(r_x);
        end
        case (i_ctl.step)
            ST_S1: begin
                r_prod <= w_prod;
                r_d0   <= i_delay;
            end
            ST_S2: begin
                r_prod <= w_prod;
                r_d1   <= i_delay;
                r_acc  <= r_prod + r_d0 + ROUND_Q30;
            end
            ST_S3: begin
                r_prod <= w_prod;
                r_y    <= sat32(r_acc >>> Q30_SHIFT);
                r_acc  <= r_d1 + r_prod;
            end
            ST_S4: begin
                r_prod <= w_prod;
                r_acc2 <= r_prod;
            end
            ST_S5: begin
                r_prod <= w_prod;
                r_acc  <= r_acc + r_prod;
            end
            ST_S6: begin
                r_acc2 <= r_acc2 + r_prod;
                r_sh   <= w_sh_clamped;
            end
            ST_S7: begin
                r_prod <= w_prod;
            end
            ST_S8: begin
                r_acc <= r_prod + w_round;
            end
            ST_S9: begin
                r_sig <= sat32(r_acc >>> r_sh);
            end
            ST_BR_END: begin
                r_total <= r_total + TW'(r_sig);
            end
            default: begin
            end
        endcase
    end

    assign o_acc  = r_acc;
    assign o_acc2 = r_acc2;

    always_comb begin
        if (r_total > T_MAX) begin
            o_total = 32'sh7FFF_FFFF;
        end else if (r_total < T_MIN) begin
            o_total = 32'sh8000_0000;
        end else begin
            o_total = r_total[31:0];
        end
    end

endmodule

/* rtl/biquad_cascade_iir_df2t.sv */
// Biquad cascade filter (transposed direct form II): a sequencer steps one shared
// multiply-accumulate unit through every biquad of every whole parallel branch.
// One input transfer carries either a sample (opcode 0) or one coefficient word
// (opcode 1). A coefficient write is stored in the cycle it is accepted (writes
// past the end of the store are dropped) and the block stays ready. A sample
// holds the input stalled from the cycle after it is accepted until its result is
// loaded into the output register: each biquad of each whole branch runs through
// the states S0 to S9, the six products going one at a time through the single
// multiplier, and when biquad_count is zero the sample passes through. The result
// waits in an output register; a stalled output holds a finished sample in
// ST_DONE until that register is free. Coefficients live in a RAM with one write
// port and one registered read port; delays in a small RAM whose valid bits clear
// at reset, so the delay line starts at zero with no clearing pass.
// Depends on biqc_pkg, biqc_coef_ram, biqc_delay_ram and biqc_alu.
`timescale 1ns / 1ps

module biquad_cascade_iir_df2t #(
    parameter int MAX_BIQUADS = biqc_pkg::MAX_BIQUADS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample / coefficient channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic [5:0]         i_coef_index,
    input  logic signed [31:0] i_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_sample_out,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import biqc_pkg::*;

    localparam int CDEPTH = MAX_BIQUADS * COEFS_PER_BIQUAD;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int DDEPTH = MAX_BIQUADS * DELAYS_PER_BIQUAD;
    localparam int DAW    = $clog2(DDEPTH);
    localparam int QW     = $clog2(MAX_BIQUADS + 1);
    localparam int CMP_W  = (CAW + 1 > 7) ? CAW + 1 : 7;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] r_biquad_count;
    logic [CFG_W-1:0] r_series_length;
    logic             w_cfg_write;
    logic             w_reg_idx;

    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biquad_count  <= '0;
            r_series_length <= CFG_W'(1);
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                REG_BIQUAD_COUNT:  r_biquad_count  <= pwdata[CFG_W-1:0];
                REG_SERIES_LENGTH: r_series_length <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_BIQUAD_COUNT:  prdata = 32'(r_biquad_count);
            REG_SERIES_LENGTH: prdata = 32'(r_series_length);
        endcase
    end

    // Clamp count and series length to what the stores can hold; a series length of zero counts as one
    logic [QW-1:0] w_count;
    logic [QW-1:0] w_ser;

    always_comb begin
        if (int'(r_biquad_count) > MAX_BIQUADS) begin
            w_count = QW'(MAX_BIQUADS);
        end else begin
            w_count = QW'(r_biquad_count);
        end
        if (r_series_length == '0) begin
            w_ser = QW'(1);
        end else if (int'(r_series_length) > MAX_BIQUADS) begin
            w_ser = QW'(MAX_BIQUADS);
        end else begin
            w_ser = QW'(r_series_length);
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    t_state   r_state, n_state;
    logic [QW-1:0] r_q, n_q;      // current biquad
    logic [QW-1:0] r_k, n_k;      // position inside the branch
    logic [2:0]    w_slot;
    logic          w_dsel;
    logic          w_dly_we;
    logic          w_out_load;
    t_alu_ctl      w_ctl;
    logic          w_in_xfer;
    logic          w_fits;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    // only whole branches run
    assign w_fits = ((QW+1)'(r_q) + (QW+1)'(w_ser)) <= (QW+1)'(w_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_q     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_q        = r_q;
        n_k        = r_k;
        w_slot     = K_B0;
        w_dsel     = 1'b0;
        w_dly_we   = 1'b0;
        w_out_load = 1'b0;
        w_ctl      = '{step: r_state, load_x: 1'b0, branch_init: 1'b0, pass_x: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && i_opcode == OP_SAMPLE) begin
                    w_ctl.load_x = 1'b1;
                    n_q          = '0;
                    n_k          = '0;
                    n_state      = ST_BRANCH;
                end
            end
            ST_BRANCH: begin
                if (w_count == '0) begin
                    w_ctl.pass_x = 1'b1;
                    n_state      = ST_DONE;
                end else if (w_fits) begin
                    w_ctl.branch_init = 1'b1;
                    n_state           = ST_S0;
                end else begin
                    n_state = ST_DONE;
                end
            end
            // read b0 and d0
            ST_S0: begin
                w_slot  = K_B0;
                w_dsel  = 1'b0;
                n_state = ST_S1;
            end
            // read b1 and d1
            ST_S1: begin
                w_slot  = K_B1;
                w_dsel  = 1'b1;
                n_state = ST_S2;
            end
            ST_S2: begin
                w_slot  = K_B2;
                n_state = ST_S3;
            end
            ST_S3: begin
                w_slot  = K_A1;
                n_state = ST_S4;
            end
            ST_S4: begin
                w_slot  = K_A2;
                n_state = ST_S5;
            end
            ST_S5: begin
                w_slot  = K_SHIFT;
                n_state = ST_S6;
            end
            // new d0 is final in the accumulator: write it back
            ST_S6: begin
                w_slot   = K_GAIN;
                w_dly_we = 1'b1;
                w_dsel   = 1'b0;
                n_state  = ST_S7;
            end
            // new d1 is final: write it back
            ST_S7: begin
                w_dly_we = 1'b1;
                w_dsel   = 1'b1;
                n_state  = ST_S8;
            end
            ST_S8: begin
                n_state = ST_S9;
            end
            // advance to the next biquad, close the branch after its last one
            ST_S9: begin
                n_q = r_q + QW'(1);
                if (r_k == w_ser - QW'(1)) begin
                    n_k     = '0;
                    n_state = ST_BR_END;
                end else begin
                    n_k     = r_k + QW'(1);
                    n_state = ST_S0;
                end
            end
            ST_BR_END: begin
                n_state = ST_BRANCH;
            end
            // hold until the output register is free
            ST_DONE: begin
                if (!o_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Stores
    // ---------------------------------------------------------------
    logic [QW+2:0]     w_cbase;
    logic [CAW-1:0]    w_craddr;
    logic [CAW-1:0]    w_cwaddr;
    logic              w_coef_we;
    logic [DAW-1:0]    w_daddr;
    logic [31:0]       w_coef_rd;
    logic [63:0]       w_dly_rd;
    logic [63:0]       w_dly_wdata;
    logic signed [63:0] w_acc;
    logic signed [63:0] w_acc2;
    logic signed [31:0] w_total;

    assign w_cbase  = (QW+3)'(r_q) * (QW+3)'(COEFS_PER_BIQUAD) + (QW+3)'(w_slot);
    assign w_craddr = CAW'(w_cbase);
    assign w_cwaddr = CAW'(i_coef_index);
    // drop writes to slots past the end of the store
    assign w_coef_we = w_in_xfer && (i_opcode == OP_COEF)
                     && (CMP_W'(i_coef_index) < CMP_W'(CDEPTH));
    assign w_daddr     = DAW'({r_q, w_dsel});
    assign w_dly_wdata = w_dsel ? w_acc2 : w_acc;

    biqc_coef_ram #(
        .DEPTH (CDEPTH),
        .AW    (CAW)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_cwaddr),
        .i_wdata (i_value),
        .i_raddr (w_craddr),
        .o_rdata (w_coef_rd)
    );

    biqc_delay_ram #(
        .DEPTH (DDEPTH),
        .AW    (DAW)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_dly_we),
        .i_waddr (w_daddr),
        .i_wdata (w_dly_wdata),
        .i_raddr (w_daddr),
        .o_rdata (w_dly_rd)
    );

    biqc_alu #(
        .MAX_BIQUADS (MAX_BIQUADS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_value (i_value),
        .i_coef  (w_coef_rd),
        .i_delay (w_dly_rd),
        .o_acc   (w_acc),
        .o_acc2  (w_acc2),
        .o_total (w_total)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic               r_out_valid;
    logic signed [31:0] r_sample_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_sample_out <= w_total;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

/* rtl/biqc_checker.sv */
// Port-level checks for the biquad cascade filter, bound to its top level.
// Depends on biqc_pkg (opcodes) and biquad_cascade_iir_df2t.
`timescale 1ns / 1ps

module biqc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_opcode,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_sample_out
);

    import biqc_pkg::*;

    // a result waiting on a stalled receiver holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_out)))
        else $error("stalled result changed or dropped");

    // a sample transfer starts the sequencer
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_opcode == OP_SAMPLE) |=> o_in_stall)
        else $error("input not stalled after a sample transfer");

    // a coefficient write leaves the block ready
    a_coef_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_opcode == OP_COEF) |=> !o_in_stall)
        else $error("input stalled after a coefficient write");

    // a new result only comes out of a busy period
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a sample in flight");

endmodule

bind biquad_cascade_iir_df2t biqc_checker u_biqc_checker (.*);

/* bench/tb.sv */
// Self-checking bench for biquad_cascade_iir_df2t: drives samples and coefficient
// words with random pacing, predicts each filtered sample and compares it.
// Depends on biqc_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb;
    import biqc_pkg::*;

    localparam int NUM_SLOTS   = MAX_BIQUADS_DEF * COEFS_PER_BIQUAD;
    localparam int DLY_DEPTH   = MAX_BIQUADS_DEF * DELAYS_PER_BIQUAD;
    localparam int RAND_ITEMS  = 1750;
    localparam int TAIL_CYCLES = 200;
    localparam longint SAT_HI  = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO  = -64'sh0000_0000_8000_0000;

    // Kinds of row in the directed table
    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_COEF,
        ROW_REG
    } t_row_kind;

    // Ways the result side holds off
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } t_stall_mode;

    // slot is the coefficient index for items, the register index for REG rows;
    // outv is only compared when known is set.
    typedef struct packed {
        t_row_kind   kind;
        logic [5:0]  slot;
        logic [31:0] word;
        logic        known;
        logic [31:0] outv;
    } t_dir_row;

    localparam int DIR_ROWS = 27;
    localparam t_dir_row PLAN [DIR_ROWS] = '{
        // after reset zero biquads are in use: samples pass straight through
        '{ROW_SAMPLE, 6'h2A, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{ROW_SAMPLE, 6'h15, 32'h8000_0000, 1'b1, 32'h8000_0000},
        '{ROW_SAMPLE, 6'h3F, 32'h0000_0000, 1'b1, 32'h0000_0000},
        // biquad 0 as a unity filter: b0 = 1.0 in Q30, gain = 1.0 after the shift of 14
        '{ROW_COEF,   6'(K_A2),    32'h0000_0000, 1'b0, 32'h0},
        '{ROW_COEF,   6'(K_A1),    32'h0000_0000, 1'b0, 32'h0},
        '{ROW_COEF,   6'(K_B2),    32'h0000_0000, 1'b0, 32'h0},
        '{ROW_COEF,   6'(K_B1),    32'h0000_0000, 1'b0, 32'h0},
        '{ROW_COEF,   6'(K_B0),    32'h4000_0000, 1'b0, 32'h0},
        '{ROW_COEF,   6'(K_SHIFT), 32'h0000_0000, 1'b0, 32'h0},
        '{ROW_COEF,   6'(K_GAIN),  32'h0000_4000, 1'b0, 32'h0},
        // slots past the last biquad are dropped
        '{ROW_COEF,   6'd63, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ROW_COEF,   6'd56, 32'h1234_5678, 1'b0, 32'h0},
        '{ROW_REG,    6'(REG_BIQUAD_COUNT),  32'd1, 1'b0, 32'h0},
        '{ROW_REG,    6'(REG_SERIES_LENGTH), 32'd1, 1'b0, 32'h0},
        '{ROW_SAMPLE, 6'h01, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{ROW_SAMPLE, 6'h3E, 32'h8000_0000, 1'b1, 32'h8000_0000},
        // series length above the maximum: one biquad cannot fill a branch, output is zero
        '{ROW_REG,    6'(REG_SERIES_LENGTH), 32'd15, 1'b0, 32'h0},
        '{ROW_SAMPLE, 6'h00, 32'h0000_1234, 1'b1, 32'h0000_0000},
        // series length zero behaves as one
        '{ROW_REG,    6'(REG_SERIES_LENGTH), 32'd0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 6'h20, 32'h0000_0100, 1'b1, 32'h0000_0100},
        // full-scale gain with the shift clamped low saturates both ways
        '{ROW_COEF,   6'(K_GAIN),  32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_COEF,   6'(K_SHIFT), 32'h8000_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, 6'h10, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{ROW_SAMPLE, 6'h0F, 32'h8000_0000, 1'b1, 32'h8000_0000},
        // shift clamped high
        '{ROW_COEF,   6'(K_SHIFT), 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 6'h33, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ROW_SAMPLE, 6'h0C, 32'hC000_0001, 1'b0, 32'h0}
    };

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic               i_opcode      = OP_SAMPLE;
    logic [5:0]         i_coef_index  = '0;
    logic signed [31:0] i_value       = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic signed [31:0] o_sample_out;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [2:0]         paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state: registers, coefficient words, 64-bit delays
    logic [3:0]  biquads_on   = 4'd0;
    logic [3:0]  chain_len    = 4'd1;
    logic [31:0] coef_mem [NUM_SLOTS];
    longint      delay_mem [DLY_DEPTH] = '{default: 0};

    logic [31:0] due_samples [$];
    logic [31:0] next_due;
    int          bad_count   = 0;
    int          burst_left  = 0;

    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_tick  = 0;
    int          stall_run   = 0;
    logic        stall_level = 1'b0;

    biquad_cascade_iir_df2t dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_coef_index (i_coef_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint clip32(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic longint coef_at(input int q, input logic [2:0] k);
        return longint'(signed'(coef_mem[q * COEFS_PER_BIQUAD + k]));
    endfunction

    // Run one sample through every whole branch, advance the delays and return
    // the saturated sum of the branch outputs; with no biquads the word passes through.
    function automatic logic [31:0] cascade_filter(input logic [31:0] word);
        int     nbq, ser, nbr, br, k, q;
        longint sig, total, acc, y, s, r;
        longint a2, a1, b2, b1, b0, sh, g;
        nbq = (biquads_on > MAX_BIQUADS_DEF) ? MAX_BIQUADS_DEF : biquads_on;
        if (nbq == 0) return word;
        ser = (chain_len == 0) ? 1 : chain_len;
        if (ser > MAX_BIQUADS_DEF) ser = MAX_BIQUADS_DEF;
        nbr = nbq / ser;
        total = 0;
        for (br = 0; br < nbr; br++) begin
            sig = longint'(signed'(word));
            for (k = 0; k < ser; k++) begin
                q  = br * ser + k;
                a2 = coef_at(q, K_A2);
                a1 = coef_at(q, K_A1);
                b2 = coef_at(q, K_B2);
                b1 = coef_at(q, K_B1);
                b0 = coef_at(q, K_B0);
                sh = coef_at(q, K_SHIFT);
                g  = coef_at(q, K_GAIN);
                // Q30 product with rounding; 64-bit sums wrap
                acc = b0 * sig + delay_mem[2*q];
                y   = clip32((acc + (longint'(1) << 29)) >>> 30);
                delay_mem[2*q]   = delay_mem[2*q+1] + b1 * sig + a1 * y;
                delay_mem[2*q+1] = b2 * sig + a2 * y;
                s = 14 + sh;
                if (s < 1) s = 1;
                if (s > 62) s = 62;
                sig = clip32((g * y + (longint'(1) << (s - 1))) >>> s);
            end
            total += sig;
        end
        r = clip32(total);
        return r[31:0];
    endfunction

    // Mostly plausible filter coefficients, with a share of raw words that
    // drive the datapath into saturation, wrap and shift clamping.
    function automatic logic [31:0] pick_coef(input int k);
        logic [31:0] w;
        if ($urandom_range(0, 9) == 0) return $urandom;
        case (k)
            K_A2, K_A1: w = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
            K_SHIFT:    w = $urandom_range(0, 24) - 12;
            K_GAIN:     w = $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
            default:    w = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] pick_sample();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        return $urandom;
    endfunction

    function automatic logic [3:0] pick_setting();
        case ($urandom_range(0, 5))
            0:       return 4'd0;
            1:       return 4'd1;
            2:       return 4'd8;
            3:       return 4'd15;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic note_fault(input string what);
        bad_count++;
        if (bad_count <= 10) $display("tb: %s", what);
    endtask

    // Present one item and hold it until the transfer. Entered and left at a
    // falling edge; valid stays high on return so back-to-back items need no
    // extra drop. The expected sample is queued at the accepting edge.
    task automatic send_item(input logic op, input logic [5:0] slot, input logic [31:0] word,
                             input logic typed, input logic [31:0] typed_out);
        int          gap;
        logic [31:0] predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   = 1'b1;
        i_opcode     = op;
        i_coef_index = slot;
        i_value      = word;
        do @(posedge i_clk); while (o_in_stall);
        if (op == OP_COEF) begin
            if (slot < NUM_SLOTS) coef_mem[slot] = word;
        end else begin
            predicted = cascade_filter(word);
            due_samples.push_back(typed ? typed_out : predicted);
        end
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every queued sample has come back, then give
    // a trailing coefficient write time to settle.
    task automatic drain();
        i_in_valid = 1'b0;
        while (due_samples.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // Setup and access phase; random upper bits check that only four are kept.
    task automatic write_reg(input logic idx, input logic [3:0] val);
        logic [31:0] w;
        w       = $urandom;
        w[3:0]  = val;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = w;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_BIQUAD_COUNT) biquads_on = val;
        else chain_len = val;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Result side: cycle through randomly chosen stall patterns, including long
    // stretches with no stall at all.
    always @(negedge i_clk) begin
        stall_tick = stall_tick + 1;
        if (stall_tick % 256 == 0) stall_mode = t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     i_out_stall = 1'b0;
            STALL_RANDOM:   i_out_stall = ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: i_out_stall = ((stall_tick % 9) < 4);
            default: begin
                if (stall_run == 0) begin
                    stall_run   = $urandom_range(1, 40);
                    stall_level = ~stall_level;
                end
                stall_run   = stall_run - 1;
                i_out_stall = stall_level;
            end
        endcase
    end

    // Compare every result transfer with the oldest queued sample.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_samples.size() == 0) begin
                note_fault($sformatf("result %h with none pending", o_sample_out));
            end else begin
                next_due = due_samples.pop_front();
                if (o_sample_out !== next_due)
                    note_fault($sformatf("sample_out expected %h got %h", next_due,
                                         o_sample_out));
            end
        end
    end

    initial begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int r, n, plen, slot;
        int top;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table; register rows wait for the filter to go idle first
        for (r = 0; r < DIR_ROWS; r++) begin
            case (PLAN[r].kind)
                ROW_REG: begin
                    drain();
                    write_reg(PLAN[r].slot[0], PLAN[r].word[3:0]);
                end
                ROW_COEF:
                    send_item(OP_COEF, PLAN[r].slot, PLAN[r].word, 1'b0, 32'h0);
                default:
                    send_item(OP_SAMPLE, PLAN[r].slot, PLAN[r].word,
                              PLAN[r].known, PLAN[r].outv);
            endcase
        end

        // load every slot before any wider setting can read it
        for (slot = 0; slot < NUM_SLOTS; slot++)
            send_item(OP_COEF, 6'(slot), pick_coef(slot % COEFS_PER_BIQUAD), 1'b0, 32'h0);

        // random phases: new setting each phase, samples with stray coefficient
        // updates mixed in, and an occasional full drain mid-phase
        n = 0;
        while (n < RAND_ITEMS) begin
            drain();
            write_reg(REG_BIQUAD_COUNT, pick_setting());
            if ($urandom_range(0, 1) == 0) begin
                top = (biquads_on == 0) ? 1 :
                      (biquads_on > MAX_BIQUADS_DEF) ? MAX_BIQUADS_DEF : biquads_on;
                write_reg(REG_SERIES_LENGTH, 4'($urandom_range(1, top)));
            end else begin
                write_reg(REG_SERIES_LENGTH, pick_setting());
            end
            plen = $urandom_range(20, 120);
            repeat (plen) begin
                if ($urandom_range(0, 7) == 0) begin
                    slot = $urandom_range(0, 63);
                    send_item(OP_COEF, 6'(slot), pick_coef(slot % COEFS_PER_BIQUAD),
                              1'b0, 32'h0);
                    if (slot < NUM_SLOTS) n++;
                end else begin
                    send_item(OP_SAMPLE, 6'($urandom), pick_sample(), 1'b0, 32'h0);
                    n++;
                end
                if ($urandom_range(0, 60) == 0) drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (bad_count == 0 && due_samples.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/biqc_pkg.sv
rtl/biqc_coef_ram.sv
rtl/biqc_delay_ram.sv
rtl/biqc_alu.sv
rtl/biquad_cascade_iir_df2t.sv
rtl/biqc_checker.sv
bench/tb.sv
